[rtl/sbrb_pkg.sv]
`default_nettype none

package sbrb_pkg;

  // Width of an effective reader count (0..15)
  localparam int ACT_W = 5;

  // Operation codes on in_kind
  localparam logic [1:0] KIND_PUBLISH = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_MARK    = 2'd2;
  localparam logic [1:0] KIND_NOP     = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_BAD_ID = 2'd2;
  localparam logic [1:0] STAT_UNPUB  = 2'd3;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_RESP
  } sbrb_state_t;

  // Control from the sequencer to the cursor unit
  typedef struct packed {
    logic       mark_en;
    logic [2:0] mark_id;
    logic       scan_clr;
    logic       scan_en;
  } sbrb_cur_ctrl_t;

endpackage

`default_nettype wire

[rtl/sbrb_ram.sv]
`default_nettype none

module sbrb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/sbrb_cursor.sv]
`default_nettype none

module sbrb_cursor import sbrb_pkg::*; #(
  parameter int MAX_READERS = 8,
  parameter int SEQ_BITS    = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sbrb_cur_ctrl_t       ctrl,
  input  wire logic [SEQ_BITS-1:0]  mark_seq,
  input  wire logic [ACT_W-1:0]     active,
  input  wire logic [SEQ_BITS-1:0]  write_count,
  output logic      [SEQ_BITS-1:0]  worst,
  output logic                      scan_last
);

  localparam int IDX_W = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;

  logic [SEQ_BITS-1:0] seen_r [MAX_READERS];
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [SEQ_BITS-1:0] worst_r, worst_nxt;
  logic [SEQ_BITS-1:0] lag;
  logic                take;

  // Seen counts: cleared by reset, one entry written by a mark
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_READERS; i++) begin
        seen_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < MAX_READERS; i++) begin
        if (ctrl.mark_en && (ACT_W'(ctrl.mark_id) == ACT_W'(i))) begin
          seen_r[i] <= mark_seq;
        end
      end
    end
  end

  // One cursor a cycle: lag modulo the counter width, keep the largest
  assign lag       = write_count - seen_r[idx_r];
  assign take      = (ACT_W'(idx_r) < active) && (lag > worst_r);
  assign scan_last = (idx_r == IDX_W'(MAX_READERS - 1));

  always_comb begin
    idx_nxt   = idx_r;
    worst_nxt = worst_r;
    if (ctrl.scan_clr) begin
      idx_nxt   = '0;
      worst_nxt = '0;
    end else if (ctrl.scan_en) begin
      idx_nxt = scan_last ? '0 : idx_r + IDX_W'(1);
      if (take) begin
        worst_nxt = lag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      worst_r <= '0;
    end else begin
      idx_r   <= idx_nxt;
      worst_r <= worst_nxt;
    end
  end

  assign worst = worst_r;

endmodule

`default_nettype wire

[rtl/spmc_broadcast_ring_buffer_core.sv]
// Broadcast event ring with one producer and up to MAX_READERS consumers.
// Each word on the input channel is a publish, a read of one slot, a mark
// of a consumer's seen count, or a no-op, and gives exactly one result word
// carrying a status, the slot data for a read, the published count and the
// seen count of the slowest registered consumer. A publish is refused as
// full once the slowest consumer lags CAPACITY-1 or more events. Each word
// passes the cursor scan, which visits one consumer cursor per cycle to
// find the largest lag, then an execute state and a response state that
// waits for the result register to be free; no new word is taken until the
// sequencer is back in idle. The slot store is a single-port-write,
// registered-read RAM and needs no clearing after reset: a read is only
// served for a sequence that has been published.
// cfg_wr_data sets the registered consumer count; write it only while idle.
`default_nettype none

module spmc_broadcast_ring_buffer_core import sbrb_pkg::*; #(
  parameter int CAPACITY    = 1024,
  parameter int MAX_READERS = 8,
  parameter int DATA_BITS   = 32,
  parameter int SEQ_BITS    = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // configuration
  input  wire logic                        cfg_wr_en,
  input  wire logic [3:0]                  cfg_wr_data,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_kind,
  input  wire logic [2:0]                  in_consumer_id,
  input  wire logic [SEQ_BITS-1:0]         in_sequence_req,
  input  wire logic signed [DATA_BITS-1:0] in_data,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_status,
  output logic signed [DATA_BITS-1:0]      out_read_data,
  output logic [SEQ_BITS-1:0]              out_published_count,
  output logic [SEQ_BITS-1:0]              out_slowest_seen
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CMP_W = (SEQ_BITS > 17) ? SEQ_BITS : 17;

  sbrb_state_t state_r, state_nxt;

  logic [3:0]           cc_r;
  logic [ACT_W-1:0]     active;
  logic [SEQ_BITS-1:0]  wc_r, wc_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // captured word
  logic [1:0]           kind_r;
  logic [SEQ_BITS-1:0]  seq_r;
  logic [DATA_BITS-1:0] data_r;
  logic                 bad_r;

  // result held between execute and output
  logic [1:0]           res_status_r, res_status_nxt;
  logic [SEQ_BITS-1:0]  res_slow_r;

  logic [1:0]           out_status_r;
  logic [DATA_BITS-1:0] out_rdata_r, out_rdata_nxt;
  logic [SEQ_BITS-1:0]  out_pub_r;
  logic [SEQ_BITS-1:0]  out_slow_r;

  logic                 in_acc;
  logic                 mark_ok;
  logic                 out_free;
  logic                 full;
  logic                 ram_we;
  logic                 res_load;
  logic                 out_load;
  logic [DATA_BITS-1:0] ram_rdata;
  logic [SEQ_BITS-1:0]  worst;
  logic                 scan_last;
  sbrb_cur_ctrl_t       cur_ctrl;

  // Effective reader count, clamped to the cursor file
  assign active = ({1'b0, cc_r} > ACT_W'(MAX_READERS)) ? ACT_W'(MAX_READERS)
                                                       : {1'b0, cc_r};

  assign in_acc   = in_valid && !in_stall;
  assign mark_ok  = (in_kind == KIND_MARK) && (ACT_W'(in_consumer_id) < active);
  assign out_free = !out_valid_r || !out_stall;
  assign full     = CMP_W'(worst) >= CMP_W'(CAPACITY - 1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc)    state_nxt = ST_SCAN;
      ST_SCAN: if (scan_last) state_nxt = ST_EXEC;
      ST_EXEC:                state_nxt = ST_RESP;
      ST_RESP: if (out_free)  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall          = (state_r != ST_IDLE);
    cur_ctrl.mark_en  = in_acc && mark_ok;
    cur_ctrl.mark_id  = in_consumer_id;
    cur_ctrl.scan_clr = in_acc;
    cur_ctrl.scan_en  = (state_r == ST_SCAN);
    res_load          = (state_r == ST_EXEC);
    ram_we            = res_load && (kind_r == KIND_PUBLISH) && !full;
    out_load          = (state_r == ST_RESP) && out_free;
  end

  // Status of the operation
  always_comb begin
    unique case (kind_r)
      KIND_PUBLISH: res_status_nxt = full ? STAT_FULL : STAT_OK;
      KIND_READ:    res_status_nxt = (seq_r >= wc_r) ? STAT_UNPUB : STAT_OK;
      KIND_MARK:    res_status_nxt = bad_r ? STAT_BAD_ID : STAT_OK;
      KIND_NOP:     res_status_nxt = STAT_OK;
    endcase
  end

  assign wc_nxt = ram_we ? wc_r + SEQ_BITS'(1) : wc_r;

  assign out_rdata_nxt = ((kind_r == KIND_READ) && (res_status_r == STAT_OK))
                         ? ram_rdata : '0;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cc_r        <= '0;
      wc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wc_r        <= wc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cc_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_kind;
      seq_r  <= in_sequence_req;
      data_r <= in_data;
      bad_r  <= !mark_ok;
    end
    // a publish leaves write_count minus the largest lag unchanged; with no
    // consumer registered the slowest simply follows the producer
    if (res_load) begin
      res_status_r <= res_status_nxt;
      res_slow_r   <= (active == '0) ? wc_nxt : wc_r - worst;
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_rdata_r  <= out_rdata_nxt;
      out_pub_r    <= wc_r;
      out_slow_r   <= res_slow_r;
    end
  end

  sbrb_cursor #(
    .MAX_READERS (MAX_READERS),
    .SEQ_BITS    (SEQ_BITS)
  ) u_cursor (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (cur_ctrl),
    .mark_seq    (in_sequence_req),
    .active      (active),
    .write_count (wc_r),
    .worst       (worst),
    .scan_last   (scan_last)
  );

  sbrb_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(wc_r)),
    .wdata (data_r),
    .raddr (AW'(seq_r)),
    .rdata (ram_rdata)
  );

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_read_data       = out_rdata_r;
  assign out_published_count = out_pub_r;
  assign out_slowest_seen    = out_slow_r;

endmodule

`default_nettype wire

[rtl/sbrb_checker.sv]
`default_nettype none

module sbrb_props import sbrb_pkg::*; #(
  parameter int DATA_BITS = 32,
  parameter int SEQ_BITS  = 32
) (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [1:0]                  out_status,
  input wire logic signed [DATA_BITS-1:0] out_read_data,
  input wire logic [SEQ_BITS-1:0]         out_published_count,
  input wire logic [SEQ_BITS-1:0]         out_slowest_seen
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_read_data) && $stable(out_published_count)
      && $stable(out_slowest_seen))
    else $error("result word changed while stalled");

  // only a successful read carries data
  a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_OK) |-> out_read_data == '0)
    else $error("read data nonzero on failed operation");

  // one word at a time: busy right after an acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while first in flight");

  // reset empties the result channel
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind spmc_broadcast_ring_buffer_core sbrb_props #(
  .DATA_BITS (DATA_BITS),
  .SEQ_BITS  (SEQ_BITS)
) u_sbrb_checker (.*);

`default_nettype wire

[tb/sbrb_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the ring core, keeps its own copy of the ring,
// predicts one answer per accepted word and compares answers in order.
module sbrb_checker import sbrb_pkg::*; #(
  parameter int CAPACITY    = 1024,
  parameter int MAX_READERS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [3:0]         cfg_wr_data,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [1:0]         in_kind,
  input  wire logic [2:0]         in_consumer_id,
  input  wire logic [31:0]        in_sequence_req,
  input  wire logic signed [31:0] in_data,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [1:0]         out_status,
  input  wire logic signed [31:0] out_read_data,
  input  wire logic [31:0]        out_published_count,
  input  wire logic [31:0]        out_slowest_seen,
  output int                      mismatches,
  output int                      outstanding,
  output logic [31:0]             model_published
);

  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_data;
    logic [31:0]        published;
    logic [31:0]        slowest;
  } ring_answer_t;

  // Shadow ring state
  logic signed [31:0] slot_copy [CAPACITY];
  logic [31:0]        pub_count;
  logic [31:0]        seen_count [MAX_READERS];
  logic [3:0]         readers_reg;
  ring_answer_t       answer_q [$];

  // Registered consumers, clipped to the number of cursors
  function automatic int live_readers();
    return (int'(readers_reg) > MAX_READERS) ? MAX_READERS : int'(readers_reg);
  endfunction

  // Largest modular distance from any live cursor to the producer
  function automatic logic [31:0] worst_lag();
    logic [31:0] worst;
    logic [31:0] lag;
    worst = '0;
    for (int i = 0; i < live_readers(); i++) begin
      lag = pub_count - seen_count[i];
      if (lag > worst) worst = lag;
    end
    return worst;
  endfunction

  // Applies one word to the shadow ring and returns the answer it should give
  function automatic ring_answer_t apply_ring_op(input logic [1:0] kind,
                                                 input logic [2:0] cid,
                                                 input logic [31:0] seq,
                                                 input logic signed [31:0] data);
    ring_answer_t ans;
    ans = '0;
    ans.status = STAT_OK;
    case (kind)
      KIND_PUBLISH: begin
        if (worst_lag() >= 32'(CAPACITY - 1)) begin
          ans.status = STAT_FULL;
        end else begin
          slot_copy[pub_count[IDX_W-1:0]] = data;
          pub_count = pub_count + 32'd1;
        end
      end
      KIND_READ: begin
        if (seq >= pub_count) ans.status = STAT_UNPUB;
        else ans.read_data = slot_copy[seq[IDX_W-1:0]];
      end
      KIND_MARK: begin
        if (int'(cid) >= live_readers()) ans.status = STAT_BAD_ID;
        else seen_count[cid] = seq;
      end
      default: ;
    endcase
    ans.published = pub_count;
    ans.slowest   = pub_count - worst_lag();
    return ans;
  endfunction

  task automatic note_mismatch(input string what, input ring_answer_t want,
                               input ring_answer_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%0t: %s: status %0d/%0d read_data %0d/%0d published %0d/%0d slowest %0d/%0d (exp/act)",
               $time, what, want.status, got.status, want.read_data, got.read_data,
               want.published, got.published, want.slowest, got.slowest);
  endtask

  // Per edge: register write, accepted input word, accepted result word
  always @(posedge clk) begin
    ring_answer_t got;
    ring_answer_t want;
    if (!rst_n) begin
      pub_count   = '0;
      readers_reg = '0;
      for (int i = 0; i < MAX_READERS; i++) seen_count[i] = '0;
      answer_q.delete();
      mismatches  = 0;
    end else begin
      if (cfg_wr_en) readers_reg = cfg_wr_data;
      if (in_valid && !in_stall)
        answer_q.push_back(apply_ring_op(in_kind, in_consumer_id, in_sequence_req, in_data));
      if (out_valid && !out_stall) begin
        got = '{out_status, out_read_data, out_published_count, out_slowest_seen};
        if (answer_q.size() == 0) begin
          note_mismatch("result with nothing due", '0, got);
        end else begin
          want = answer_q.pop_front();
          if (want.status !== got.status || want.read_data !== got.read_data ||
              want.published !== got.published || want.slowest !== got.slowest)
            note_mismatch("result mismatch", want, got);
        end
      end
    end
    outstanding     = answer_q.size();
    model_published = pub_count;
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import sbrb_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 6;
  localparam int IDLE_PCT      = 18;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_WORDS  = 55;
  localparam int FILL_WORDS    = 20;
  localparam int REFILL_WORDS  = 30;
  localparam int NEAR_FULL_LAG = 1016;
  localparam int TIMEOUT_NS    = 3_000_000;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [3:0]         cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_kind;
  logic [2:0]         in_consumer_id;
  logic [31:0]        in_sequence_req;
  logic signed [31:0] in_data;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_status;
  logic signed [31:0] out_read_data;
  logic [31:0]        out_published_count;
  logic [31:0]        out_slowest_seen;

  int                 mismatches;
  int                 outstanding;
  logic [31:0]        model_published;
  bit                 no_idle;
  bit                 hold_req;

  spmc_broadcast_ring_buffer_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_consumer_id      (in_consumer_id),
    .in_sequence_req     (in_sequence_req),
    .in_data             (in_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_read_data       (out_read_data),
    .out_published_count (out_published_count),
    .out_slowest_seen    (out_slowest_seen)
  );

  sbrb_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_consumer_id      (in_consumer_id),
    .in_sequence_req     (in_sequence_req),
    .in_data             (in_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_read_data       (out_read_data),
    .out_published_count (out_published_count),
    .out_slowest_seen    (out_slowest_seen),
    .mismatches          (mismatches),
    .outstanding         (outstanding),
    .model_published     (model_published)
  );

  always begin
    clk = 1'b0;
    #(CLK_HALF);
    clk = 1'b1;
    #(CLK_HALF);
  end

  // Offer one word; entered and left at a falling edge, valid left high
  task automatic send_word(input logic [1:0] kind, input logic [2:0] cid,
                           input logic [31:0] seq, input logic [31:0] data);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_consumer_id  <= cid;
    in_sequence_req <= seq;
    in_data         <= data;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stop offering and wait until every answer has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic set_readers(input logic [3:0] n);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly well-formed traffic near the producer cursor, some noise
  task automatic random_word();
    int          pick;
    logic [31:0] pub;
    logic [31:0] span;
    logic [31:0] seq;
    pub  = model_published;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      send_word(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), $urandom(), $urandom());
    end else if (pick < 50) begin
      send_word(KIND_PUBLISH, 3'($urandom_range(0, 7)), $urandom(), $urandom());
    end else if (pick < 78) begin
      if (pub == 0 || $urandom_range(0, 9) == 0) begin
        seq = pub + $urandom_range(0, 2);
      end else begin
        span = (pub > 1200) ? 32'd1200 : pub - 32'd1;
        seq  = pub - 32'd1 - $urandom_range(0, span);
      end
      send_word(KIND_READ, 3'($urandom_range(0, 7)), seq, $urandom());
    end else if (pick < 95) begin
      span = (pub < 30) ? pub : 32'd30;
      send_word(KIND_MARK, 3'($urandom_range(0, 7)), pub - $urandom_range(0, span),
                $urandom());
    end else begin
      send_word(KIND_NOP, 3'($urandom_range(0, 7)), $urandom(), $urandom());
    end
  endtask

  // Receiver: random stalls, one long hold-off on request
  initial begin
    int hold_left;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Stimulus and verdict
  initial begin
    logic [3:0] phase_readers [4];
    phase_readers   = '{4'd3, 4'd15, 4'd8, 4'd5};
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_valid        = 1'b0;
    in_kind         = KIND_NOP;
    in_consumer_id  = '0;
    in_sequence_req = '0;
    in_data         = '0;
    no_idle         = 1'b0;
    hold_req        = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: all eight consumers registered
    set_readers(4'd8);
    send_word(KIND_READ, 3'd0, 32'd0, 32'd0);                    // empty ring read
    send_word(KIND_NOP, 3'd7, 32'hffff_ffff, 32'h7fff_ffff);
    send_word(KIND_PUBLISH, 3'd0, 32'd0, 32'h8000_0000);
    send_word(KIND_PUBLISH, 3'd7, 32'hffff_ffff, 32'h7fff_ffff);
    send_word(KIND_PUBLISH, 3'd0, 32'd0, 32'hffff_ffff);
    send_word(KIND_PUBLISH, 3'd0, 32'd0, 32'd0);
    send_word(KIND_READ, 3'd0, 32'd0, 32'd0);
    send_word(KIND_READ, 3'd7, 32'd3, 32'hffff_ffff);
    send_word(KIND_READ, 3'd0, 32'd4, 32'd0);                    // first unpublished
    send_word(KIND_READ, 3'd0, 32'hffff_ffff, 32'd0);
    send_word(KIND_MARK, 3'd0, 32'd4, 32'd0);
    send_word(KIND_MARK, 3'd7, 32'd2, 32'd0);
    send_word(KIND_MARK, 3'd5, 32'd100, 32'd0);                  // cursor ahead of producer
    send_word(KIND_PUBLISH, 3'd0, 32'd0, 32'h1234_5678);         // refused as full
    send_word(KIND_MARK, 3'd5, 32'd4, 32'd0);
    send_word(KIND_PUBLISH, 3'd0, 32'd0, 32'h5a5a_a5a5);
    // Two consumers: ids from two upwards are rejected
    set_readers(4'd2);
    send_word(KIND_MARK, 3'd2, 32'd0, 32'd0);
    send_word(KIND_MARK, 3'd7, 32'd1, 32'd0);
    send_word(KIND_MARK, 3'd1, 32'd5, 32'd0);
    send_word(KIND_PUBLISH, 3'd0, 32'd0, 32'hdead_beef);
    // Count above the cursor total is clipped
    set_readers(4'd15);
    send_word(KIND_MARK, 3'd7, 32'd6, 32'd0);
    send_word(KIND_PUBLISH, 3'd0, 32'd0, 32'h0000_0001);
    // No consumers: slowest follows the producer
    set_readers(4'd0);
    send_word(KIND_PUBLISH, 3'd0, 32'd0, 32'hffff_fffe);
    send_word(KIND_MARK, 3'd0, 32'd0, 32'd0);

    repeat (RANDOM_WORDS) random_word();

    // One consumer left just short of full: publish until refused,
    // read back old and unpublished sequences, then release the consumer
    set_readers(4'd1);
    no_idle = 1'b1;
    send_word(KIND_MARK, 3'd0, model_published - 32'(NEAR_FULL_LAG), $urandom());
    repeat (FILL_WORDS)
      send_word(KIND_PUBLISH, 3'($urandom_range(0, 7)), $urandom(), $urandom());
    repeat (20)
      send_word(KIND_READ, 3'd0, model_published - 32'd1 - $urandom_range(0, 1100), 32'd0);
    send_word(KIND_MARK, 3'd0, model_published - 32'd100, $urandom());
    repeat (REFILL_WORDS)
      send_word(KIND_PUBLISH, 3'($urandom_range(0, 7)), $urandom(), $urandom());
    repeat (20)
      send_word(KIND_READ, 3'd0, model_published - 32'd1 - $urandom_range(0, 1100), 32'd0);
    no_idle = 1'b0;

    foreach (phase_readers[p]) begin
      set_readers(phase_readers[p]);
      if (p == 0) hold_req = 1'b1;
      repeat (RANDOM_WORDS) random_word();
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[files.f]
rtl/sbrb_pkg.sv
rtl/sbrb_ram.sv
rtl/sbrb_cursor.sv
rtl/spmc_broadcast_ring_buffer_core.sv
rtl/sbrb_checker.sv
tb/sbrb_checker.sv
tb/testbench.sv
